>>> design/usb_bulk_only_scsi_target_top_defines.svh
// Assertion macros used by the port-level checker of the bulk-only target.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef USB_BULK_ONLY_SCSI_TARGET_TOP_DEFINES_SVH
`define USB_BULK_ONLY_SCSI_TARGET_TOP_DEFINES_SVH

// property sampled on the rising clock, muted while reset is low
`define UBOT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property sampled on the rising clock, also checked in reset
`define UBOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ubot_pkg.sv
// Package for the bulk-only mass storage target: payload structs, codes,
// phase enum and the fixed reply tables. No dependencies.
package ubot_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  dest;
        logic [7:0]  byte_value;
        logic [31:0] block_address;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_COLLECT,
        PH_REPLY,
        PH_READ_SRC,
        PH_READ_FILL,
        PH_RECEIVE,
        PH_ECHO,
        PH_STATUS
    } t_phase;

    localparam logic [1:0] KIND_HOST  = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_IN_RDY = 2'd2;

    localparam logic [1:0] DEST_IN    = 2'd0;
    localparam logic [1:0] DEST_STORE = 2'd1;
    localparam logic [1:0] DEST_REQ   = 2'd2;

    localparam logic [1:0] CFG_READ_SRC   = 2'd0;
    localparam logic [1:0] CFG_WRITE_SINK = 2'd1;
    localparam logic [1:0] CFG_LAST_BLOCK = 2'd2;

    localparam logic [7:0] OP_INQUIRY     = 8'h12;
    localparam logic [7:0] OP_FORMAT_CAP  = 8'h23;
    localparam logic [7:0] OP_READ_CAP    = 8'h25;
    localparam logic [7:0] OP_MODE_SENSE  = 8'h1A;
    localparam logic [7:0] OP_READ10      = 8'h28;
    localparam logic [7:0] OP_WRITE10     = 8'h2A;

    localparam logic [1:0] SEL_INQUIRY    = 2'd0;
    localparam logic [1:0] SEL_FORMAT_CAP = 2'd1;
    localparam logic [1:0] SEL_READ_CAP   = 2'd2;
    localparam logic [1:0] SEL_MODE_SENSE = 2'd3;

    localparam int WRAPPER_BYTES = 31;
    localparam int STATUS_BYTES  = 13;

    localparam logic [7:0] INQUIRY [36] = '{
        8'h00, 8'h80, 8'h00, 8'h01, 8'h1F, 8'h00, 8'h00, 8'h00,
        8'h42, 8'h72, 8'h61, 8'h6E, 8'h64, 8'h6F, 8'h6E, 8'h57,
        8'h55, 8'h53, 8'h42, 8'h20, 8'h46, 8'h6C, 8'h61, 8'h73,
        8'h68, 8'h20, 8'h44, 8'h72, 8'h69, 8'h76, 8'h65, 8'h00,
        8'h30, 8'h2E, 8'h30, 8'h31
    };

    function automatic logic [6:0] table_len(input logic [1:0] sel);
        logic [6:0] len;
        case (sel)
            SEL_INQUIRY:    len = 7'd36;
            SEL_FORMAT_CAP: len = 7'd12;
            default:        len = 7'd8;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] table_byte(input logic [1:0] sel, input logic [5:0] idx,
                                              input logic [31:0] last_blk,
                                              input logic [31:0] sector);
        logic [7:0] b;
        b = 8'h00;
        case (sel)
            SEL_INQUIRY: begin
                if (idx < 6'd36) b = INQUIRY[idx];
            end
            SEL_FORMAT_CAP: begin
                case (idx)
                    6'd3:    b = 8'h08;
                    6'd6:    b = 8'h10;
                    6'd8:    b = 8'h01;
                    6'd9:    b = sector[23:16];
                    6'd10:   b = sector[15:8];
                    6'd11:   b = sector[7:0];
                    default: b = 8'h00;
                endcase
            end
            SEL_READ_CAP: begin
                case (idx)
                    6'd0:    b = last_blk[31:24];
                    6'd1:    b = last_blk[23:16];
                    6'd2:    b = last_blk[15:8];
                    6'd3:    b = last_blk[7:0];
                    6'd4:    b = sector[31:24];
                    6'd5:    b = sector[23:16];
                    6'd6:    b = sector[15:8];
                    6'd7:    b = sector[7:0];
                    default: b = 8'h00;
                endcase
            end
            default: begin
                if (idx == 6'd0) b = 8'h12;
                else if (idx == 6'd7) b = 8'h1C;
            end
        endcase
        return b;
    endfunction

endpackage

>>> design/ubot_front.sv
// Front end: two-entry input queue that takes host, storage and IN-ready
// transfers and hands them to the engine. Uses ubot_pkg.
module ubot_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ubot_pkg::t_in_item i_in,
    output logic              o_item_valid,
    output ubot_pkg::t_in_item o_item,
    input  logic              i_item_take
);
    import ubot_pkg::*;

    t_in_item   r_buf [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_in_stall   = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_buf[r_rd];
    // kind 3 never does anything, so it is not queued
    assign push = i_in_valid && !o_in_stall && (i_in.kind != 2'd3);
    assign pop  = o_item_valid && i_item_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_buf[r_wr] <= i_in;
    end
endmodule

>>> design/ubot_engine.sv
// Back end: command wrapper collection, decode and the data/status phases.
// Produces up to two result transfers per item. Uses ubot_pkg.
module ubot_engine #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_item_valid,
    input  ubot_pkg::t_in_item  i_item,
    output logic               o_item_take,
    input  logic               i_room,
    output logic [1:0]         o_res_cnt,
    output ubot_pkg::t_out_item o_res0,
    output ubot_pkg::t_out_item o_res1
);
    import ubot_pkg::*;

    localparam int OFF_W = $clog2(SECTOR_BYTES);
    localparam logic [OFF_W-1:0] OFF_END = OFF_W'(SECTOR_BYTES - 1);
    localparam logic [31:0] SECTOR_W = 32'(SECTOR_BYTES);

    logic        r_src_present, r_sink_present;
    logic [31:0] r_last_block;

    logic [7:0]  r_wrap [WRAPPER_BYTES];
    logic [7:0]  r_tag  [4];
    logic [4:0]  r_widx, n_widx;
    t_phase      r_phase, n_phase;
    logic [15:0] r_left, n_left;
    logic [15:0] r_len;
    logic [15:0] r_partial, n_partial;
    logic [7:0]  r_op;
    logic        r_dir;
    logic [31:0] r_addr_cap;
    logic [OFF_W-1:0] r_off, n_off;
    logic [31:0] r_blk, n_blk;
    logic [5:0]  r_ridx, n_ridx;
    logic [1:0]  r_rsel, n_rsel;

    logic        go;
    logic [15:0] pos, left_dec;
    logic        sec_end;
    logic [15:0] whole;

    assign go          = i_item_valid && i_room;
    assign o_item_take = go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_present  <= 1'b0;
            r_sink_present <= 1'b0;
            r_last_block   <= 32'd4095;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_READ_SRC:   r_src_present  <= i_cfg_data[0];
                CFG_WRITE_SINK: r_sink_present <= i_cfg_data[0];
                CFG_LAST_BLOCK: r_last_block   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // wrapper bytes and the decoded fields are captured as they arrive
    always_ff @(posedge i_clk) begin
        if (go && r_phase == PH_COLLECT && i_item.kind == KIND_HOST) begin
            r_wrap[r_widx] <= i_item.data;
            case (r_widx)
                5'd4:  r_tag[0] <= i_item.data;
                5'd5:  r_tag[1] <= i_item.data;
                5'd6:  r_tag[2] <= i_item.data;
                5'd7:  r_tag[3] <= i_item.data;
                5'd8:  r_len[7:0]  <= i_item.data;
                5'd9:  r_len[15:8] <= i_item.data;
                5'd12: r_dir <= i_item.data[7];
                5'd15: r_op  <= i_item.data;
                5'd17: r_addr_cap[31:24] <= i_item.data;
                5'd18: r_addr_cap[23:16] <= i_item.data;
                5'd19: r_addr_cap[15:8]  <= i_item.data;
                5'd20: r_addr_cap[7:0]   <= i_item.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_COLLECT;
            r_widx    <= 5'd0;
            r_left    <= 16'd0;
            r_partial <= 16'd0;
            r_off     <= '0;
            r_blk     <= 32'd0;
            r_ridx    <= 6'd0;
            r_rsel    <= 2'd0;
        end else if (go) begin
            r_phase   <= n_phase;
            r_widx    <= n_widx;
            r_left    <= n_left;
            r_partial <= n_partial;
            r_off     <= n_off;
            r_blk     <= n_blk;
            r_ridx    <= n_ridx;
            r_rsel    <= n_rsel;
        end
    end

    assign pos      = r_len - r_left;
    assign left_dec = r_left - 16'd1;
    assign sec_end  = (r_off == OFF_END);
    assign whole    = r_len - 16'(r_len % SECTOR_BYTES);

    always_comb begin
        n_phase   = r_phase;
        n_widx    = r_widx;
        n_left    = r_left;
        n_partial = r_partial;
        n_off     = r_off;
        n_blk     = r_blk;
        n_ridx    = r_ridx;
        n_rsel    = r_rsel;
        o_res_cnt = 2'd0;
        o_res0    = '0;
        o_res1    = '0;
        case (r_phase)
            PH_COLLECT: begin
                if (i_item.kind == KIND_HOST) begin
                    if (r_widx == 5'(WRAPPER_BYTES - 1)) begin
                        n_widx    = 5'd0;
                        n_blk     = r_addr_cap;
                        n_off     = '0;
                        n_ridx    = 6'd0;
                        n_left    = 16'd0;
                        n_partial = 16'(r_len % SECTOR_BYTES);
                        if (r_op == OP_INQUIRY || r_op == OP_FORMAT_CAP ||
                            r_op == OP_READ_CAP || r_op == OP_MODE_SENSE) begin
                            if (r_op == OP_INQUIRY)         n_rsel = SEL_INQUIRY;
                            else if (r_op == OP_FORMAT_CAP) n_rsel = SEL_FORMAT_CAP;
                            else if (r_op == OP_READ_CAP)   n_rsel = SEL_READ_CAP;
                            else                            n_rsel = SEL_MODE_SENSE;
                            n_phase = PH_REPLY;
                        end else if (r_op == OP_READ10) begin
                            n_left = whole;
                            if (whole == 16'd0) begin
                                n_phase = PH_STATUS;
                            end else if (r_src_present) begin
                                o_res_cnt = 2'd1;
                                o_res0    = '{DEST_REQ, 8'h00, r_addr_cap, 1'b0};
                                n_phase   = PH_READ_SRC;
                            end else begin
                                n_phase = PH_READ_FILL;
                            end
                        end else begin
                            n_left = r_len;
                            if (r_len == 16'd0)                   n_phase = PH_STATUS;
                            else if (r_op != OP_WRITE10 && r_dir) n_phase = PH_ECHO;
                            else                                  n_phase = PH_RECEIVE;
                        end
                    end else begin
                        n_widx = r_widx + 5'd1;
                    end
                end
            end
            PH_REPLY: begin
                if (i_item.kind == KIND_IN_RDY) begin
                    o_res_cnt = 2'd1;
                    o_res0 = '{DEST_IN,
                               table_byte(r_rsel, r_ridx, r_last_block, SECTOR_W),
                               32'd0, ({1'b0, r_ridx} + 7'd1 >= table_len(r_rsel))};
                    n_ridx = r_ridx + 6'd1;
                    if (o_res0.last) begin
                        n_ridx  = 6'd0;
                        n_phase = PH_STATUS;
                    end
                end
            end
            PH_READ_SRC, PH_READ_FILL: begin
                if ((r_phase == PH_READ_SRC && i_item.kind == KIND_STORE) ||
                    (r_phase == PH_READ_FILL && i_item.kind == KIND_IN_RDY)) begin
                    o_res_cnt = 2'd1;
                    o_res0 = '{DEST_IN, (r_phase == PH_READ_SRC) ? i_item.data : 8'hFF,
                               r_blk, sec_end};
                    n_off  = r_off + 1'b1;
                    n_left = left_dec;
                    if (sec_end) begin
                        n_off = '0;
                        n_blk = r_blk + 32'd1;
                        // next sector is requested as soon as this one ends
                        if (left_dec != 16'd0 && r_phase == PH_READ_SRC) begin
                            o_res_cnt = 2'd2;
                            o_res1 = '{DEST_REQ, 8'h00, r_blk + 32'd1, 1'b0};
                        end
                    end
                    if (left_dec == 16'd0) n_phase = PH_STATUS;
                end
            end
            PH_RECEIVE: begin
                if (i_item.kind == KIND_HOST) begin
                    if (r_op == OP_WRITE10 && r_left > r_partial) begin
                        if (r_sink_present) begin
                            o_res_cnt = 2'd1;
                            o_res0 = '{DEST_STORE, i_item.data, r_blk, sec_end};
                        end
                        n_off = r_off + 1'b1;
                        if (sec_end) begin
                            n_off = '0;
                            n_blk = r_blk + 32'd1;
                        end
                    end
                    n_left = left_dec;
                    if (left_dec == 16'd0) n_phase = PH_STATUS;
                end
            end
            PH_ECHO: begin
                if (i_item.kind == KIND_IN_RDY) begin
                    o_res_cnt = 2'd1;
                    o_res0 = '{DEST_IN,
                               (pos < 16'(WRAPPER_BYTES)) ? r_wrap[pos[4:0]] : 8'h00,
                               32'd0, (r_left == 16'd1)};
                    n_left = left_dec;
                    if (left_dec == 16'd0) n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (i_item.kind == KIND_IN_RDY) begin
                    o_res_cnt = 2'd1;
                    o_res0.dest = DEST_IN;
                    o_res0.block_address = 32'd0;
                    o_res0.last = (r_ridx >= 6'(STATUS_BYTES - 1));
                    case (r_ridx)
                        6'd0: o_res0.byte_value = 8'h55;
                        6'd1: o_res0.byte_value = 8'h53;
                        6'd2: o_res0.byte_value = 8'h42;
                        6'd3: o_res0.byte_value = 8'h53;
                        6'd4, 6'd5, 6'd6, 6'd7: o_res0.byte_value = r_tag[r_ridx[1:0]];
                        default: o_res0.byte_value = 8'h00;
                    endcase
                    n_ridx = r_ridx + 6'd1;
                    if (o_res0.last) begin
                        n_ridx  = 6'd0;
                        n_widx  = 5'd0;
                        n_phase = PH_COLLECT;
                    end
                end
            end
            default: n_phase = PH_COLLECT;
        endcase
        // results only count for an item that is actually taken
        if (!go) o_res_cnt = 2'd0;
    end
endmodule

>>> design/ubot_outq.sv
// Output queue: four entries, takes up to two results a cycle from the
// engine and presents one transfer at a time. Uses ubot_pkg.
module ubot_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_cnt,
    input  ubot_pkg::t_out_item i_res0,
    input  ubot_pkg::t_out_item i_res1,
    output logic               o_room,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ubot_pkg::t_out_item o_out
);
    import ubot_pkg::*;

    t_out_item  r_buf [4];
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_cnt;
    logic       pop;

    // room for a worst-case item of two results
    assign o_room      = (r_cnt <= 3'd2);
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out       = r_buf[r_rd];
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 2'd0;
            r_wr  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= r_wr + i_push_cnt;
            r_rd  <= r_rd + 2'(pop);
            r_cnt <= r_cnt + 3'(i_push_cnt) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_buf[r_wr] <= i_res0;
        if (i_push_cnt == 2'd2) r_buf[r_wr + 2'd1] <= i_res1;
    end
endmodule

>>> design/usb_bulk_only_scsi_target_top.sv
// USB bulk-only mass storage target, SCSI subset.
// Channel in: host bytes (kind 0), storage sector bytes (kind 1) and bulk IN
// credits (kind 2), valid/stall. Channel out: bytes to bulk IN, bytes to
// storage write and sector read requests, valid/stall. Config: valid/ready
// write port, index 0 read source, 1 write sink, 2 last block; ready is
// always high, and writes belong in idle periods with nothing in flight.
// One item is taken per cycle while the output queue has room. An item reaches
// the engine from the registered input queue, and its results are written into
// the registered output queue before they show at the output. The rate is set
// by the engine's single update per item; a read sector end can give two
// results, drained one per output transfer.
// Reset (synchronous, active low) empties both queues, returns to wrapper
// collection and loads the register defaults. When the receiver stalls the
// four-entry output queue fills, the engine halts, and the two-entry input
// queue raises o_in_stall once full.
module usb_bulk_only_scsi_target_top #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ubot_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ubot_pkg::t_out_item  o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import ubot_pkg::*;

    logic       item_valid, item_take, room;
    t_in_item   item;
    logic [1:0] res_cnt;
    t_out_item  res0, res1;

    assign o_cfg_ready = 1'b1;

    ubot_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_item_valid(item_valid), .o_item(item), .i_item_take(item_take)
    );

    ubot_engine #(.SECTOR_BYTES(SECTOR_BYTES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_item_valid(item_valid), .i_item(item), .o_item_take(item_take),
        .i_room(room), .o_res_cnt(res_cnt), .o_res0(res0), .o_res1(res1)
    );

    ubot_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_cnt(res_cnt), .i_res0(res0), .i_res1(res1), .o_room(room),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );
endmodule

>>> design/ubot_checker.sv
// Port-level checker for the bulk-only target, bound to the top level.
// Uses ubot_pkg and the assertion macros header.
`include "usb_bulk_only_scsi_target_top_defines.svh"

module ubot_port_asserts (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ubot_pkg::t_out_item o_out,
    input logic               o_cfg_ready
);
    import ubot_pkg::*;

    `UBOT_ASSERT(a_out_empty_after_reset, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_out_valid, "output valid straight after reset")
    `UBOT_ASSERT(a_in_open_after_reset, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_in_stall, "input stalled straight after reset")
    `UBOT_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)), "stalled output transfer changed")
    `UBOT_ASSERT(a_dest_legal, i_clk, i_rst_n, o_out_valid |-> (o_out.dest != 2'd3 && o_cfg_ready), "illegal destination or config port closed")
endmodule

bind usb_bulk_only_scsi_target_top ubot_port_asserts u_port_asserts (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
    .o_cfg_ready(o_cfg_ready)
);

>>> sim/ubot_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the bulk-only mass storage target: predicts every output transfer
// from the accepted input and register writes and compares in order. Needs ubot_pkg.
module ubot_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  ubot_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  ubot_pkg::t_out_item i_out,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    import ubot_pkg::*;

    localparam int SECTOR = 512;
    localparam logic [7:0] STATUS_SIG [4] = '{8'h55, 8'h53, 8'h42, 8'h53};

    logic        src_on, sink_on;
    logic [31:0] last_blk;
    logic [7:0]  cbw [WRAPPER_BYTES];
    int          cbw_idx;
    t_phase      phase;
    logic [15:0] remaining;
    int          sec_off;
    logic [31:0] blk;
    int          rep_idx;
    logic [1:0]  rep_sel;
    t_out_item   expected_q [$];

    function automatic logic [15:0] cbw_len();
        return {cbw[9], cbw[8]};
    endfunction

    function automatic logic [7:0] reply_byte(input logic [1:0] sel, input int i);
        logic [31:0] sz;
        sz = SECTOR;
        case (sel)
            SEL_INQUIRY:    return (i < 36) ? INQUIRY[i] : 8'h00;
            SEL_FORMAT_CAP: begin
                if (i == 3) return 8'h08;
                if (i == 6) return 8'h10;
                if (i == 8) return 8'h01;
                if (i >= 9 && i < 12) return sz[8*(11-i) +: 8];
                return 8'h00;
            end
            SEL_READ_CAP: begin
                if (i < 4) return last_blk[8*(3-i) +: 8];
                if (i < 8) return sz[8*(7-i) +: 8];
                return 8'h00;
            end
            default: return (i == 0) ? 8'h12 : ((i == 7) ? 8'h1C : 8'h00);
        endcase
    endfunction

    function automatic int reply_len(input logic [1:0] sel);
        return (sel == SEL_INQUIRY) ? 36 : ((sel == SEL_FORMAT_CAP) ? 12 : 8);
    endfunction

    task automatic expect_out(input logic [1:0] d, input logic [7:0] v,
                              input logic [31:0] a, input logic l);
        t_out_item it;
        it.dest = d;
        it.byte_value = v;
        it.block_address = a;
        it.last = l;
        expected_q.push_back(it);
    endtask

    task automatic decode_wrapper();
        logic [7:0] op;
        op = cbw[15];
        blk = {cbw[17], cbw[18], cbw[19], cbw[20]};
        sec_off = 0;
        rep_idx = 0;
        remaining = '0;
        if (op == OP_INQUIRY || op == OP_FORMAT_CAP || op == OP_READ_CAP
                || op == OP_MODE_SENSE) begin
            rep_sel = (op == OP_INQUIRY) ? SEL_INQUIRY : (op == OP_FORMAT_CAP) ?
                      SEL_FORMAT_CAP : (op == OP_READ_CAP) ? SEL_READ_CAP : SEL_MODE_SENSE;
            phase = PH_REPLY;
        end else if (op == OP_READ10) begin
            remaining = cbw_len() & 16'hFE00;
            if (remaining == 0) begin
                phase = PH_STATUS;
            end else if (src_on) begin
                expect_out(DEST_REQ, 8'h00, blk, 1'b0);
                phase = PH_READ_SRC;
            end else begin
                phase = PH_READ_FILL;
            end
        end else begin
            remaining = cbw_len();
            if (remaining == 0) phase = PH_STATUS;
            else if (op != OP_WRITE10 && cbw[12][7]) phase = PH_ECHO;
            else phase = PH_RECEIVE;
        end
    endtask

    task automatic sector_byte(input logic [7:0] v);
        logic fin;
        fin = (sec_off == SECTOR - 1);
        expect_out(DEST_IN, v, blk, fin);
        sec_off++;
        remaining--;
        if (fin) begin
            sec_off = 0;
            blk++;
            if (remaining != 0 && phase == PH_READ_SRC) expect_out(DEST_REQ, 8'h00, blk, 1'b0);
        end
        if (remaining == 0) phase = PH_STATUS;
    endtask

    task automatic predict_transfer(input logic [1:0] k, input logic [7:0] d);
        logic        fin;
        logic [15:0] pos;
        logic [7:0]  b;
        case (phase)
            PH_COLLECT: if (k == KIND_HOST) begin
                cbw[cbw_idx] = d;
                cbw_idx++;
                if (cbw_idx >= WRAPPER_BYTES) begin
                    cbw_idx = 0;
                    decode_wrapper();
                end
            end
            PH_REPLY: if (k == KIND_IN_RDY) begin
                fin = (rep_idx + 1 >= reply_len(rep_sel));
                expect_out(DEST_IN, reply_byte(rep_sel, rep_idx), '0, fin);
                rep_idx++;
                if (fin) begin
                    rep_idx = 0;
                    phase = PH_STATUS;
                end
            end
            PH_READ_SRC:  if (k == KIND_STORE) sector_byte(d);
            PH_READ_FILL: if (k == KIND_IN_RDY) sector_byte(8'hFF);
            PH_RECEIVE: if (k == KIND_HOST) begin
                // trailing partial-sector bytes of a write are swallowed
                if (cbw[15] == OP_WRITE10 && remaining > (cbw_len() % SECTOR)) begin
                    fin = (sec_off == SECTOR - 1);
                    if (sink_on) expect_out(DEST_STORE, d, blk, fin);
                    sec_off++;
                    if (fin) begin
                        sec_off = 0;
                        blk++;
                    end
                end
                remaining--;
                if (remaining == 0) phase = PH_STATUS;
            end
            PH_ECHO: if (k == KIND_IN_RDY) begin
                pos = cbw_len() - remaining;
                b = (pos < WRAPPER_BYTES) ? cbw[pos] : 8'h00;
                expect_out(DEST_IN, b, '0, remaining == 1);
                remaining--;
                if (remaining == 0) phase = PH_STATUS;
            end
            PH_STATUS: if (k == KIND_IN_RDY) begin
                b = 8'h00;
                if (rep_idx < 4) b = STATUS_SIG[rep_idx];
                else if (rep_idx < 8) b = cbw[rep_idx];
                fin = (rep_idx >= STATUS_BYTES - 1);
                expect_out(DEST_IN, b, '0, fin);
                rep_idx++;
                if (fin) begin
                    rep_idx = 0;
                    cbw_idx = 0;
                    phase = PH_COLLECT;
                end
            end
            default: phase = PH_COLLECT;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            src_on = 1'b0;
            sink_on = 1'b0;
            last_blk = 32'd4095;
            cbw_idx = 0;
            phase = PH_COLLECT;
            remaining = '0;
            sec_off = 0;
            blk = '0;
            rep_idx = 0;
            rep_sel = SEL_INQUIRY;
            expected_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_READ_SRC:   src_on = i_cfg_data[0];
                    CFG_WRITE_SINK: sink_on = i_cfg_data[0];
                    CFG_LAST_BLOCK: last_blk = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected output transfer %p", i_out);
                end else begin
                    want = expected_q.pop_front();
                    if (want !== i_out) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected %p, got %p", want, i_out);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_transfer(i_in.kind, i_in.data);
        end
        o_pending = expected_q.size();
    end

endmodule

>>> sim/tb_usb_bulk_only_scsi_target_top.sv
`timescale 1ns / 100ps
// Top of the bulk-only target testbench: clock, reset, command stimulus and the
// verdict. Needs ubot_pkg, usb_bulk_only_scsi_target_top and ubot_checker.
module tb_usb_bulk_only_scsi_target_top;
    import ubot_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 5000;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_stall;
    t_in_item    i_in;
    logic        o_out_valid, i_out_stall;
    t_out_item   o_out;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          errors, pending;
    int          idle_cycles;
    int          items_sent;
    bit          no_gaps, long_hold;
    logic        src_on;

    usb_bulk_only_scsi_target_top dut (.*);

    ubot_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out(o_out),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog: cycles with no transfer on either channel and no config write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL usb_bulk_only_scsi_target_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver back-pressure
    initial begin
        int r;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                i_out_stall <= (r >= 60);
                if (r < 40) repeat ($urandom_range(1, 30)) @(posedge i_clk);
                else if (r < 95) repeat ($urandom_range(1, 3)) @(posedge i_clk);
                else repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input logic [1:0] k, input logic [7:0] d);
        int g;
        i_in_valid <= 1'b1;
        i_in <= '{kind: k, data: d};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // kind 3 is never used; in wrapper collection credits and storage bytes are too
    task automatic send_with_noise(input logic [1:0] k, input logic [7:0] d,
                                   input bit collecting);
        if ($urandom_range(0, 19) == 0)
            send(collecting ? 2'($urandom_range(1, 3)) : KIND_UNUSED, 8'($urandom));
        send(k, d);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_READ_SRC) src_on = val[0];
    endtask

    task automatic run_command(input logic [7:0] op, input logic [15:0] len,
                               input bit dir_in, input logic [31:0] addr);
        logic [7:0] w [WRAPPER_BYTES];
        int         n;
        logic [1:0] k;
        for (int i = 0; i < WRAPPER_BYTES; i++) w[i] = 8'($urandom);
        {w[9], w[8]} = len;
        w[12][7] = dir_in;
        w[15] = op;
        {w[17], w[18], w[19], w[20]} = addr;
        for (int i = 0; i < WRAPPER_BYTES; i++) send_with_noise(KIND_HOST, w[i], 1'b1);
        n = 0;
        k = KIND_IN_RDY;
        if (op == OP_INQUIRY) n = 36;
        else if (op == OP_FORMAT_CAP) n = 12;
        else if (op == OP_READ_CAP || op == OP_MODE_SENSE) n = 8;
        else if (op == OP_READ10) begin
            n = len & 16'hFE00;
            if (src_on) k = KIND_STORE;
        end else begin
            n = len;
            if (op == OP_WRITE10 || !dir_in) k = KIND_HOST;
        end
        for (int i = 0; i < n; i++) send_with_noise(k, 8'($urandom), 1'b0);
        for (int i = 0; i < STATUS_BYTES; i++) send_with_noise(KIND_IN_RDY, 8'($urandom), 1'b0);
    endtask

    // whole-sector transfers are covered by the directed part
    task automatic random_command();
        logic [7:0]  op;
        logic [15:0] len;
        logic [31:0] addr;
        int          r;
        r = $urandom_range(0, 7);
        case (r)
            0: op = OP_INQUIRY;
            1: op = OP_FORMAT_CAP;
            2: op = OP_READ_CAP;
            3: op = OP_MODE_SENSE;
            4: op = OP_READ10;
            5: op = OP_WRITE10;
            default: op = 8'($urandom);
        endcase
        if (op == OP_READ10)
            len = 16'($urandom_range(0, 511));
        else if (op == OP_WRITE10)
            len = 16'($urandom_range(0, 40));
        else if (r < 4)
            len = 16'($urandom);
        else
            len = 16'($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 40));
        addr = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
        no_gaps = ($urandom_range(0, 3) == 0);
        run_command(op, len, 1'($urandom), addr);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_READ_SRC;
        i_cfg_data = '0;
        idle_cycles = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        long_hold = 1'b0;
        src_on = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: whole sectors from storage under a long hold, then to storage
        write_reg(CFG_READ_SRC, 32'd1);
        write_reg(CFG_WRITE_SINK, 32'hFFFF_FFFF);
        write_reg(CFG_LAST_BLOCK, 32'hFFFF_FFFF);
        long_hold = 1'b1;
        run_command(OP_READ10, 16'd512, 1'b1, 32'hFFFF_FFFF);
        wait_drained();
        run_command(OP_WRITE10, 16'd515, 1'b0, 32'hFFFF_FFFE);

        // random phases through several register settings
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_reg(CFG_READ_SRC, 32'(p[0]));
            write_reg(CFG_WRITE_SINK, 32'(p[1] ^ p[0]));
            write_reg(CFG_LAST_BLOCK, 32'($urandom));
            items_sent = 0;
            while (items_sent < 30) random_command();
        end
        no_gaps = 1'b0;
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS usb_bulk_only_scsi_target_top");
        end else begin
            $display("FAIL usb_bulk_only_scsi_target_top");
        end
        $finish;
    end

endmodule
